// ----- hdl/lwf_pkg.sv -----
package lwf_pkg;

    localparam int RNG_W  = 16;
    localparam int SUM_W  = 28;
    localparam int CNT_W  = 12;
    localparam int IDX_W  = 12;
    localparam int DT_W   = 24;
    localparam int ERR_W  = 17;
    localparam int SPD_W  = 8;
    localparam int NUM_W  = 48;
    localparam int DEN_W  = 34;
    localparam int CALC_W = 51;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX      = 12'd4095;
    localparam logic [SPD_W-1:0] STRAIGHT_SPEED = 8'd140;
    localparam int               DEADBAND_MM    = 20;

    // PD gains per mode; the derivative gain carries the 700000 scale
    localparam logic [5:0]  KP_BOTH   = 6'd40;
    localparam logic [24:0] KDK_BOTH  = 25'd14000000;
    localparam logic [7:0]  BASE_BOTH = 8'd140;
    localparam logic [5:0]  KP_ONE    = 6'd25;
    localparam logic [24:0] KDK_ONE   = 25'd17500000;
    localparam logic [7:0]  BASE_ONE  = 8'd135;
    localparam logic [DEN_W-1:0] DT_SCALE = 34'd1000;

    typedef enum logic [2:0] {
        REG_LEFT_FIRST  = 3'd0,
        REG_LEFT_LAST   = 3'd1,
        REG_RIGHT_FIRST = 3'd2,
        REG_RIGHT_LAST  = 3'd3,
        REG_LO_MM       = 3'd4,
        REG_HI_MM       = 3'd5,
        REG_DESIRED     = 3'd6,
        REG_OPEN_LIMIT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0] left_first;
        logic [IDX_W-1:0] left_last;
        logic [IDX_W-1:0] right_first;
        logic [IDX_W-1:0] right_last;
        logic [RNG_W-1:0] lo_mm;
        logic [RNG_W-1:0] hi_mm;
        logic [RNG_W-1:0] desired;
        logic [RNG_W-1:0] open_limit;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] lsum;
        logic [CNT_W-1:0] lcnt;
        logic [SUM_W-1:0] rsum;
        logic [CNT_W-1:0] rcnt;
        logic [DT_W-1:0]  dt;
    } scan_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LDIV,
        BK_LWAIT,
        BK_RDIV,
        BK_RWAIT,
        BK_MODE,
        BK_MUL1,
        BK_MUL2,
        BK_SUM,
        BK_PDIV,
        BK_PWAIT,
        BK_SPEED,
        BK_OUT
    } back_state_t;

    function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [CALC_W-1:0] v);
        logic [SPD_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > 255)
            r = '1;
        else
            r = v[SPD_W-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/lwf_ifs.sv -----
interface lwf_sample_if import lwf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RNG_W-1:0] range_mm;
    logic             sample_ok;
    logic             scan_end;
    logic [DT_W-1:0]  elapsed_us;

    modport source (output valid, range_mm, sample_ok, scan_end, elapsed_us, input ready);
    modport sink   (input valid, range_mm, sample_ok, scan_end, elapsed_us, output ready);
endinterface

interface lwf_speed_if import lwf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SPD_W-1:0] left_speed;
    logic [SPD_W-1:0] right_speed;

    modport source (output valid, left_speed, right_speed, input ready);
    modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

// ----- hdl/lwf_front.sv -----
module lwf_front import lwf_pkg::*; #(
    parameter int MAX_SAMPLES = 4096,
    parameter int RANGE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    lwf_sample_if.sink  in_ch,
    input  logic        q_full,
    output logic        push,
    output scan_t       push_data
);

    localparam int CTR_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (CTR_W > IDX_W) ? CTR_W : IDX_W;
    localparam int MASK_W = (RANGE_BITS < RNG_W) ? RANGE_BITS : RNG_W;
    localparam logic [RNG_W-1:0] RANGE_MASK = {RNG_W{1'b1}} >> (RNG_W - MASK_W);
    localparam logic [CTR_W-1:0] CTR_LIMIT  = CTR_W'(MAX_SAMPLES);

    logic [CTR_W-1:0] idx_reg;
    logic [SUM_W-1:0] lsum_reg, rsum_reg, lsum_acc, rsum_acc;
    logic [CNT_W-1:0] lcnt_reg, rcnt_reg, lcnt_acc, rcnt_acc;
    logic             accept, live, in_range, l_hit, r_hit;
    logic [RNG_W-1:0] rng;
    logic [CMP_W-1:0] idx_ext;

    // classify the sample against the range limits and both windows
    always_comb
    begin
        in_ch.ready = !q_full;
        accept   = in_ch.valid && in_ch.ready;
        rng      = in_ch.range_mm & RANGE_MASK;
        live     = idx_reg < CTR_LIMIT;
        in_range = in_ch.sample_ok && (rng >= cfg.lo_mm) && (rng <= cfg.hi_mm);
        idx_ext  = CMP_W'(idx_reg);
        l_hit = live && in_range && (lcnt_reg < COUNT_MAX)
             && (idx_ext >= CMP_W'(cfg.left_first)) && (idx_ext <= CMP_W'(cfg.left_last));
        r_hit = live && in_range && (rcnt_reg < COUNT_MAX)
             && (idx_ext >= CMP_W'(cfg.right_first)) && (idx_ext <= CMP_W'(cfg.right_last));
        lsum_acc = lsum_reg + (l_hit ? SUM_W'(rng) : '0);
        rsum_acc = rsum_reg + (r_hit ? SUM_W'(rng) : '0);
        lcnt_acc = lcnt_reg + CNT_W'(l_hit);
        rcnt_acc = rcnt_reg + CNT_W'(r_hit);
    end

    // hand the finished scan, final sample included, to the queue
    always_comb
    begin
        push           = accept && in_ch.scan_end;
        push_data.lsum = lsum_acc;
        push_data.lcnt = lcnt_acc;
        push_data.rsum = rsum_acc;
        push_data.rcnt = rcnt_acc;
        push_data.dt   = in_ch.elapsed_us;
    end

    // advance the accumulators, clear them at scan end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            lsum_reg <= '0;
            rsum_reg <= '0;
            lcnt_reg <= '0;
            rcnt_reg <= '0;
        end
        else if (accept)
        begin
            if (in_ch.scan_end)
            begin
                idx_reg  <= '0;
                lsum_reg <= '0;
                rsum_reg <= '0;
                lcnt_reg <= '0;
                rcnt_reg <= '0;
            end
            else
            begin
                idx_reg  <= idx_reg + CTR_W'(live);
                lsum_reg <= lsum_acc;
                rsum_reg <= rsum_acc;
                lcnt_reg <= lcnt_acc;
                rcnt_reg <= rcnt_acc;
            end
        end
    end

endmodule

// ----- hdl/lwf_queue.sv -----
module lwf_queue import lwf_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  scan_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output scan_t q_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    scan_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    assign full    = count_reg == CNT_QW'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = mem[rd_ptr_reg];

    // store scan totals
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_QW'(push) - CNT_QW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("scan pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_QW'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> q_valid)
        else $error("pushed item not visible");

endmodule

// ----- hdl/lwf_div.sv -----
module lwf_div import lwf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [DEN_W:0]    rem_sh, rem_sub;
    logic              fits;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        fits    = rem_sh >= {1'b0, den_reg};
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

endmodule

// ----- hdl/lwf_back.sv -----
module lwf_back import lwf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  scan_t        q_data,
    output logic         pop,
    lwf_speed_if.source  out_ch
);

    back_state_t state_reg, state_next;

    scan_t                     job_reg;
    logic [RNG_W-1:0]          lavg_reg, ravg_reg;
    logic                      first_reg;
    logic signed [ERR_W-1:0]   prior_reg, err_reg;
    logic [5:0]                kp_reg;
    logic [24:0]               kdk_reg;
    logic [7:0]                base_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [22:0]        p1_reg;
    logic signed [44:0]        p2_reg;
    logic signed [NUM_W-1:0]   p3_reg;
    logic [DEN_W-1:0]          den_reg;
    logic                      neg_reg, rnz_reg;
    logic [NUM_W-1:0]          mag_reg, q_reg;
    logic [SPD_W-1:0]          spd_l_reg, spd_r_reg;
    logic                      out_valid_reg;
    logic [SPD_W-1:0]          out_l_reg, out_r_reg;

    logic                      has_l, has_r, far, load_out, div_start, div_done;
    logic [NUM_W-1:0]          div_num, div_quo;
    logic [DEN_W-1:0]          div_den, div_rem;
    logic signed [ERR_W:0]     l_s, r_s, des_s, e_raw, diff;
    logic signed [ERR_W-1:0]   e_dead;
    logic signed [NUM_W-1:0]   num_sum;
    logic [NUM_W:0]            q_up;
    logic signed [CALC_W-1:0]  a_s, b_s;

    lwf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // mode selection and error
    always_comb
    begin
        has_l = job_reg.lcnt != '0;
        has_r = job_reg.rcnt != '0;
        l_s   = $signed({2'b00, lavg_reg});
        r_s   = $signed({2'b00, ravg_reg});
        des_s = $signed({2'b00, cfg.desired});
        far   = has_l ? (lavg_reg > cfg.open_limit) : (ravg_reg > cfg.open_limit);
        if (has_l && has_r)
            e_raw = r_s - l_s;
        else if (has_r)
            e_raw = r_s - des_s;
        else if (has_l)
            e_raw = des_s - l_s;
        else
            e_raw = '0;
        if ((e_raw > -(ERR_W+1)'(DEADBAND_MM)) && (e_raw < (ERR_W+1)'(DEADBAND_MM)))
            e_dead = '0;
        else
            e_dead = ERR_W'(e_raw);
        diff    = $signed({err_reg[ERR_W-1], err_reg}) - $signed({prior_reg[ERR_W-1], prior_reg});
        num_sum = (dt_reg != '0) ? (p3_reg + NUM_W'(p2_reg)) : NUM_W'(p1_reg);
        q_up    = {1'b0, q_reg} + (NUM_W+1)'(rnz_reg);
        a_s     = neg_reg ? -$signed(CALC_W'(q_up)) : $signed(CALC_W'(q_reg));
        b_s     = neg_reg ? $signed(CALC_W'(q_reg)) : -$signed(CALC_W'(q_up));
    end

    // shared divider operands
    always_comb
    begin
        case (state_reg)
            BK_LDIV:
            begin
                div_num = NUM_W'({job_reg.lsum, 1'b0}) + NUM_W'(job_reg.lcnt);
                div_den = DEN_W'({job_reg.lcnt, 1'b0});
            end
            BK_RDIV:
            begin
                div_num = NUM_W'({job_reg.rsum, 1'b0}) + NUM_W'(job_reg.rcnt);
                div_den = DEN_W'({job_reg.rcnt, 1'b0});
            end
            default:
            begin
                div_num = mag_reg;
                div_den = den_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (q_valid) state_next = BK_LDIV;
            BK_LDIV:  state_next = has_l ? BK_LWAIT : BK_RDIV;
            BK_LWAIT: if (div_done) state_next = BK_RDIV;
            BK_RDIV:  state_next = has_r ? BK_RWAIT : BK_MODE;
            BK_RWAIT: if (div_done) state_next = BK_MODE;
            BK_MODE:  state_next = ((has_l != has_r) && far) ? BK_OUT : BK_MUL1;
            BK_MUL1:  state_next = BK_MUL2;
            BK_MUL2:  state_next = BK_SUM;
            BK_SUM:   state_next = BK_PDIV;
            BK_PDIV:  state_next = BK_PWAIT;
            BK_PWAIT: if (div_done) state_next = BK_SPEED;
            BK_SPEED: state_next = BK_OUT;
            BK_OUT:   if (!out_valid_reg || out_ch.ready) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        pop       = (state_reg == BK_IDLE) && q_valid;
        div_start = ((state_reg == BK_LDIV) && has_l) || ((state_reg == BK_RDIV) && has_r)
                 || (state_reg == BK_PDIV);
        load_out  = (state_reg == BK_OUT) && (!out_valid_reg || out_ch.ready);
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_speed  = out_l_reg;
    assign out_ch.right_speed = out_r_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            first_reg     <= 1'b1;
            prior_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_MODE)
                first_reg <= 1'b0;
            if (state_reg == BK_SPEED)
                prior_reg <= err_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
                job_reg <= q_data;
            BK_LWAIT:
                lavg_reg <= div_quo[RNG_W-1:0];
            BK_RWAIT:
                ravg_reg <= div_quo[RNG_W-1:0];
            BK_MODE:
            begin
                err_reg   <= e_dead;
                dt_reg    <= first_reg ? '0 : job_reg.dt;
                spd_l_reg <= STRAIGHT_SPEED;
                spd_r_reg <= STRAIGHT_SPEED;
                if (has_l && has_r)
                begin
                    kp_reg   <= KP_BOTH;
                    kdk_reg  <= KDK_BOTH;
                    base_reg <= BASE_BOTH;
                end
                else if (has_l || has_r)
                begin
                    kp_reg   <= KP_ONE;
                    kdk_reg  <= KDK_ONE;
                    base_reg <= BASE_ONE;
                end
                else
                begin
                    kp_reg   <= '0;
                    kdk_reg  <= '0;
                    base_reg <= STRAIGHT_SPEED;
                end
            end
            BK_MUL1:
            begin
                p1_reg  <= $signed({1'b0, kp_reg}) * err_reg;
                p2_reg  <= $signed({1'b0, kdk_reg}) * diff;
                den_reg <= (dt_reg != '0) ? DEN_W'(dt_reg) * DT_SCALE : DT_SCALE;
            end
            BK_MUL2:
                p3_reg <= p1_reg * $signed({1'b0, dt_reg});
            BK_SUM:
            begin
                neg_reg <= num_sum < 0;
                mag_reg <= (num_sum < 0) ? NUM_W'(-num_sum) : NUM_W'(num_sum);
            end
            BK_PWAIT:
            begin
                q_reg   <= div_quo;
                rnz_reg <= div_rem != '0;
            end
            BK_SPEED:
            begin
                spd_l_reg <= clamp_speed($signed(CALC_W'(base_reg)) + a_s);
                spd_r_reg <= clamp_speed($signed(CALC_W'(base_reg)) + b_s);
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_l_reg <= spd_l_reg;
            out_r_reg <= spd_r_reg;
        end
    end

endmodule

// ----- hdl/lidar_wall_following_pd_unit.sv -----
// Wall-following PD steering from a lidar sample stream.
// in_ch carries one range sample per item; an item with scan_end closes
// the scan and carries the elapsed time since the previous scan.
// out_ch carries one left/right speed pair per scan.
// Samples are taken at one item per cycle; the front end sums both wall
// windows as they arrive. A closed scan goes into a two-entry queue, and
// in_ch.ready drops only while that queue is full.
// The back end turns one scan into speeds with up to three 48-step serial
// divisions (left average, right average, PD term) on one shared divider;
// the finished pair then sits in the output register. When out_ch stalls
// the result is held, the back end waits, and the queue keeps taking
// samples until it holds two closed scans.
// Configuration goes through the APB port; it is for the user to do only
// while the block is idle, and the block itself does not enforce it.
// Reset clears the accumulators, the queue, the stored error and marks
// the next scan as the first one (no derivative term).
module lidar_wall_following_pd_unit import lwf_pkg::*; #(
    parameter int MAX_SAMPLES = 4096,
    parameter int RANGE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lwf_sample_if.sink  in_ch,
    lwf_speed_if.source out_ch
);

    cfg_t     cfg_reg;
    reg_idx_t addr_idx;
    logic     wr_en, q_full, push, pop, q_valid;
    scan_t    push_data, q_data;

    assign pready   = 1'b1;
    assign addr_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en    = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_first  <= 12'd89;
            cfg_reg.left_last   <= 12'd91;
            cfg_reg.right_first <= 12'd269;
            cfg_reg.right_last  <= 12'd271;
            cfg_reg.lo_mm       <= 16'd50;
            cfg_reg.hi_mm       <= 16'd12000;
            cfg_reg.desired     <= 16'd150;
            cfg_reg.open_limit  <= 16'd500;
        end
        else if (wr_en)
        begin
            case (addr_idx)
                REG_LEFT_FIRST:  cfg_reg.left_first  <= pwdata[IDX_W-1:0];
                REG_LEFT_LAST:   cfg_reg.left_last   <= pwdata[IDX_W-1:0];
                REG_RIGHT_FIRST: cfg_reg.right_first <= pwdata[IDX_W-1:0];
                REG_RIGHT_LAST:  cfg_reg.right_last  <= pwdata[IDX_W-1:0];
                REG_LO_MM:       cfg_reg.lo_mm       <= pwdata[RNG_W-1:0];
                REG_HI_MM:       cfg_reg.hi_mm       <= pwdata[RNG_W-1:0];
                REG_DESIRED:     cfg_reg.desired     <= pwdata[RNG_W-1:0];
                REG_OPEN_LIMIT:  cfg_reg.open_limit  <= pwdata[RNG_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (addr_idx)
            REG_LEFT_FIRST:  prdata = 32'(cfg_reg.left_first);
            REG_LEFT_LAST:   prdata = 32'(cfg_reg.left_last);
            REG_RIGHT_FIRST: prdata = 32'(cfg_reg.right_first);
            REG_RIGHT_LAST:  prdata = 32'(cfg_reg.right_last);
            REG_LO_MM:       prdata = 32'(cfg_reg.lo_mm);
            REG_HI_MM:       prdata = 32'(cfg_reg.hi_mm);
            REG_DESIRED:     prdata = 32'(cfg_reg.desired);
            REG_OPEN_LIMIT:  prdata = 32'(cfg_reg.open_limit);
            default:         prdata = '0;
        endcase
    end

    lwf_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .RANGE_BITS  (RANGE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    lwf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    lwf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
